FILE: rtl/bmcv_pkg.sv
// ----------------------------------------------------------------------------
// bmcv_pkg
// Shared widths and types for the block mean and variation coefficient block.
// ----------------------------------------------------------------------------
package bmcv_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COUNT_W   = 13;
   localparam int SUM_W     = 28;
   localparam int SQ_W      = 44;
   localparam int POS_W     = 32;
   localparam int MEAN_W    = 24;
   localparam int CV_W      = 24;
   localparam int MEAN_FRAC = 8;
   localparam int DIV_W     = SUM_W + MEAN_FRAC;
   localparam int SQR_W     = 2 * SUM_W;
   localparam int D_SHIFT   = 32;
   localparam int ROOT_W    = 104;
   localparam int MAX_BLOCK = 4096;

   localparam logic [COUNT_W-1:0] SPAN_RESET = 13'd1024;

   typedef struct packed {
      logic [POS_W-1:0]   start;
      logic [COUNT_W-1:0] length;
      logic [SUM_W-1:0]   sum;
      logic [SQ_W-1:0]    square_sum;
   } job_type;

   typedef struct packed {
      logic [POS_W-1:0]   start;
      logic [COUNT_W-1:0] length;
      logic [MEAN_W-1:0]  mean;
      logic [CV_W-1:0]    cv;
   } result_type;

endpackage

FILE: rtl/bmcv_if.sv
// ----------------------------------------------------------------------------
// bmcv channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bmcv_req_if import bmcv_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                last_of_stream;

   modport source (output valid, output sample, output last_of_stream, input ready);
   modport sink   (input valid, input sample, input last_of_stream, output ready);
endinterface

interface bmcv_rsp_if import bmcv_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [POS_W-1:0]   block_start;
   logic [COUNT_W-1:0] block_length;
   logic [MEAN_W-1:0]  mean_value;
   logic [CV_W-1:0]    variation_coeff;

   modport source (output valid, output block_start, output block_length,
                   output mean_value, output variation_coeff, input ready);
   modport sink   (input valid, input block_start, input block_length,
                   input mean_value, input variation_coeff, output ready);
endinterface

interface bmcv_csr_if import bmcv_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] span;

   modport source (output valid, output span, input ready);
   modport sink   (input valid, input span, output ready);
endinterface

FILE: rtl/bmcv_calc.sv
// ----------------------------------------------------------------------------
// bmcv_calc
// Sequential block statistics: n*Q - S*S, mean by restoring division and
// variation coefficient by bitwise root search, all but S*S on one shared adder.
// ----------------------------------------------------------------------------
module bmcv_calc import bmcv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_ready,
   output logic       res_valid,
   output result_type res,
   input  logic       res_ready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIFF = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_ROOT = 3'd4;
   localparam logic [2:0] ST_HOLD = 3'd5;

   localparam logic [1:0] PH_TMP  = 2'd0;
   localparam logic [1:0] PH_PC   = 2'd1;
   localparam logic [1:0] PH_CAND = 2'd2;
   localparam logic [1:0] PH_TEST = 2'd3;

   localparam int CNT_W   = $clog2(DIV_W);
   localparam int T2_SHIFT = 2 * (CV_W - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(COUNT_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);

   logic [2:0]         state_ff, state_in;
   logic [1:0]         phase_ff, phase_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [SUM_W-1:0]   s_ff, s_in;
   logic [COUNT_W-1:0] nmul_ff, nmul_in;
   logic [ROOT_W-1:0]  mcand_ff, mcand_in;
   logic [ROOT_W-1:0]  acc_ff, acc_in;
   logic [SQR_W-1:0]   s2_ff, s2_in;
   logic [ROOT_W-1:0]  d_ff, d_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [ROOT_W-1:0]  p_ff, p_in;
   logic [ROOT_W-1:0]  c_ff, c_in;
   logic [ROOT_W-1:0]  t2_ff, t2_in;
   logic [ROOT_W-1:0]  tmp_ff, tmp_in;
   logic [CV_W-1:0]    bit_ff, bit_in;
   logic [CV_W-1:0]    root_ff, root_in;

   logic [SQR_W-1:0]   s_sq;
   logic [ROOT_W-1:0]  rem_shift;
   logic               alu_sub;
   logic [ROOT_W-1:0]  alu_a, alu_b;
   logic [ROOT_W:0]    alu_sum;
   logic               alu_carry;

   assign s_sq      = s_ff * s_ff;
   assign rem_shift = {acc_ff[ROOT_W-2:0], quo_ff[DIV_W-1]};

   // shared adder; on subtract, carry out set means a >= b
   assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {ROOT_W{alu_sub}}}
                      + {{ROOT_W{1'b0}}, alu_sub};
   assign alu_carry = alu_sum[ROOT_W];

   always_comb begin
      alu_sub = 1'b0;
      alu_a   = acc_ff;
      alu_b   = '0;
      unique case (state_ff)
         ST_MUL: begin
            alu_b = nmul_ff[0] ? mcand_ff : '0;
         end
         ST_DIFF: begin
            alu_sub = 1'b1;
            alu_b   = ROOT_W'(s2_ff);
         end
         ST_DIV: begin
            alu_sub = 1'b1;
            alu_a   = rem_shift;
            alu_b   = ROOT_W'(n_ff);
         end
         ST_ROOT: begin
            case (phase_ff)
               PH_TMP: begin
                  alu_a = c_ff;
                  alu_b = t2_ff;
               end
               PH_PC: begin
                  alu_a = p_ff;
                  alu_b = c_ff;
               end
               PH_CAND: begin
                  alu_a = acc_ff;
                  alu_b = tmp_ff;
               end
               default: begin
                  alu_sub = 1'b1;
                  alu_a   = d_ff;
                  alu_b   = acc_ff;
               end
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      start_in = start_ff;
      n_in     = n_ff;
      s_in     = s_ff;
      nmul_in  = nmul_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      s2_in    = s2_ff;
      d_in     = d_ff;
      quo_in   = quo_ff;
      p_in     = p_ff;
      c_in     = c_ff;
      t2_in    = t2_ff;
      tmp_in   = tmp_ff;
      bit_in   = bit_ff;
      root_in  = root_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               start_in = job.start;
               n_in     = job.length;
               s_in     = job.sum;
               nmul_in  = job.length;
               mcand_in = ROOT_W'(job.square_sum);
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in   = alu_sum[ROOT_W-1:0];
            mcand_in = mcand_ff << 1;
            nmul_in  = nmul_ff >> 1;
            s2_in    = s_sq;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            d_in     = alu_carry ? (alu_sum[ROOT_W-1:0] << D_SHIFT) : '0;
            quo_in   = {s_ff, {MEAN_FRAC{1'b0}}};
            acc_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            acc_in = alu_carry ? alu_sum[ROOT_W-1:0] : rem_shift;
            quo_in = {quo_ff[DIV_W-2:0], alu_carry};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               root_in = '0;
               if (s_ff == '0) begin
                  state_in = ST_HOLD;
               end else begin
                  p_in     = '0;
                  c_in     = '0;
                  t2_in    = ROOT_W'(s2_ff) << T2_SHIFT;
                  bit_in   = {1'b1, {(CV_W-1){1'b0}}};
                  phase_in = PH_TMP;
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            phase_in = phase_ff + 2'd1;
            case (phase_ff)
               PH_TMP: begin
                  tmp_in = alu_sum[ROOT_W-1:0];
               end
               PH_PC: begin
                  acc_in = alu_sum[ROOT_W-1:0];
               end
               PH_CAND: begin
                  acc_in = alu_sum[ROOT_W-1:0];
               end
               default: begin
                  // candidate square against d * 2^32
                  if (alu_carry) begin
                     p_in    = acc_ff;
                     c_in    = tmp_ff >> 1;
                     root_in = root_ff | bit_ff;
                  end else begin
                     c_in = c_ff >> 1;
                  end
                  t2_in  = t2_ff >> 2;
                  bit_in = bit_ff >> 1;
                  if (bit_ff[0]) begin
                     state_in = ST_HOLD;
                  end
               end
            endcase
         end
         ST_HOLD: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_TMP;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      start_ff <= start_in;
      n_ff     <= n_in;
      s_ff     <= s_in;
      nmul_ff  <= nmul_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      s2_ff    <= s2_in;
      d_ff     <= d_in;
      quo_ff   <= quo_in;
      p_ff     <= p_in;
      c_ff     <= c_in;
      t2_ff    <= t2_in;
      tmp_ff   <= tmp_in;
      bit_ff   <= bit_in;
      root_ff  <= root_in;
   end

   assign job_ready  = (state_ff == ST_IDLE);
   assign res_valid  = (state_ff == ST_HOLD);
   assign res.start  = start_ff;
   assign res.length = n_ff;
   assign res.mean   = quo_ff[MEAN_W-1:0];
   assign res.cv     = root_ff;

   a_div_rem_below_n: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (acc_ff < ROOT_W'(n_ff)))
      else $error("division remainder not below block length");

   a_root_bit_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> $onehot(bit_ff))
      else $error("root search bit not one-hot");

   a_root_square_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (p_ff <= d_ff))
      else $error("accepted root square exceeds target");

endmodule

FILE: rtl/block_mean_and_cv.sv
// ----------------------------------------------------------------------------
// block_mean_and_cv
// A request that does not close a block is accepted whenever the calculator
// is idle. A closing request starts the calculator; ready then stays low
// until it is idle again, also while an earlier response is stalled. Steps
// on the shared 104-bit adder: multiply, difference, divide, root search
// (skipped when the block sum is zero), hold, then the response register.
// Reset: synchronous, clears counters and position, block size back to 1024.
// ----------------------------------------------------------------------------
module block_mean_and_cv import bmcv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bmcv_req_if.sink   req_chan,
   bmcv_rsp_if.source rsp_chan,
   bmcv_csr_if.sink   csr_chan
);

   logic [COUNT_W-1:0]    span_ff, span_in;
   logic [COUNT_W-1:0]    sample_count_ff, sample_count_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [POS_W-1:0]      cur_start_ff, cur_start_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_res_ff, rsp_res_in;

   logic [COUNT_W-1:0]    bs_eff;
   logic [COUNT_W-1:0]    count_next;
   logic [SUM_W-1:0]      sum_next;
   logic [SQ_W-1:0]       sq_next;
   logic [POS_W-1:0]      start_pos;
   logic [2*SAMPLE_W-1:0] x_sq;
   logic                  req_accept;
   logic                  close_block;

   logic                  calc_job_valid;
   logic                  calc_job_ready;
   job_type               calc_job;
   logic                  calc_res_valid;
   logic                  calc_res_ready;
   result_type            calc_res;

   assign x_sq       = req_chan.sample * req_chan.sample;
   assign req_accept = req_chan.valid & req_chan.ready;

   always_comb begin
      if (span_ff == '0) begin
         bs_eff = COUNT_W'(1);
      end else if (span_ff > COUNT_W'(MAX_BLOCK)) begin
         bs_eff = COUNT_W'(MAX_BLOCK);
      end else begin
         bs_eff = span_ff;
      end
   end

   assign count_next  = sample_count_ff + COUNT_W'(1);
   assign sum_next    = sum_ff + SUM_W'(req_chan.sample);
   assign sq_next     = sq_ff + SQ_W'(x_sq);
   assign start_pos   = (sample_count_ff == '0) ? pos_ff : cur_start_ff;
   assign close_block = (count_next >= bs_eff) | req_chan.last_of_stream;

   assign calc_job_valid      = req_accept & close_block;
   assign calc_job.start      = start_pos;
   assign calc_job.length     = count_next;
   assign calc_job.sum        = sum_next;
   assign calc_job.square_sum = sq_next;

   always_comb begin
      span_in         = span_ff;
      sample_count_in = sample_count_ff;
      sum_in          = sum_ff;
      sq_in           = sq_ff;
      pos_in          = pos_ff;
      cur_start_in    = cur_start_ff;
      if (csr_chan.valid) begin
         span_in = csr_chan.span;
      end
      if (req_accept) begin
         cur_start_in = start_pos;
         pos_in       = req_chan.last_of_stream ? '0 : pos_ff + POS_W'(1);
         if (close_block) begin
            sample_count_in = '0;
            sum_in          = '0;
            sq_in           = '0;
         end else begin
            sample_count_in = count_next;
            sum_in          = sum_next;
            sq_in           = sq_next;
         end
      end
   end

   // response register frees the calculator while the response waits
   assign calc_res_ready = ~rsp_valid_ff | rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (calc_res_valid & calc_res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = calc_res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff         <= SPAN_RESET;
         sample_count_ff <= '0;
         sum_ff          <= '0;
         sq_ff           <= '0;
         pos_ff          <= '0;
         cur_start_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         span_ff         <= span_in;
         sample_count_ff <= sample_count_in;
         sum_ff          <= sum_in;
         sq_ff           <= sq_in;
         pos_ff          <= pos_in;
         cur_start_ff    <= cur_start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   bmcv_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .job_valid (calc_job_valid),
      .job       (calc_job),
      .job_ready (calc_job_ready),
      .res_valid (calc_res_valid),
      .res       (calc_res),
      .res_ready (calc_res_ready)
   );

   assign req_chan.ready           = calc_job_ready;
   assign csr_chan.ready           = 1'b1;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.block_start     = rsp_res_ff.start;
   assign rsp_chan.block_length    = rsp_res_ff.length;
   assign rsp_chan.mean_value      = rsp_res_ff.mean;
   assign rsp_chan.variation_coeff = rsp_res_ff.cv;

   a_launch_when_idle: assert property (@(posedge clock) disable iff (reset)
      calc_job_valid |-> calc_job_ready)
      else $error("block closed while calculator busy");

   a_count_below_max: assert property (@(posedge clock) disable iff (reset)
      sample_count_ff < COUNT_W'(MAX_BLOCK))
      else $error("open block count reached maximum block size");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff & ~rsp_chan.ready) |=> (rsp_valid_ff & $stable(rsp_res_ff)))
      else $error("stalled response dropped or changed");

endmodule

FILE: sim/block_mean_and_cv_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_mean_and_cv_tb
// Streams coverage samples into the block under a range of block sizes and
// idle patterns. Each closed block is predicted locally or given by the plan
// (start, length, Q16.8 mean, Q8.16 variation coefficient); compared by field.
// ----------------------------------------------------------------------------
module block_mean_and_cv_tb;
   import bmcv_pkg::*;

   localparam int SETTLE_CYCLES  = 160;
   localparam int HOLD_CYCLES    = 3000;
   localparam int WATCHDOG_LIMIT = 10000;
   localparam int PHASE_ITEMS    = 290;
   localparam int TAIL_ITEMS     = 100;

   typedef enum bit {STEP_WRITE_SIZE, STEP_SAMPLE} step_kind_type;

   typedef struct {
      step_kind_type        kind;
      logic [COUNT_W-1:0]   size;
      logic [SAMPLE_W-1:0]  sample;
      logic                 last;
      bit                   typed;
      result_type           known;
   } plan_row_type;

   logic clock;
   logic reset;

   bmcv_req_if req_if ();
   bmcv_rsp_if rsp_if ();
   bmcv_csr_if csr_if ();

   block_mean_and_cv dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Block statistics mirror
   logic [COUNT_W-1:0] size_reg;
   logic [COUNT_W-1:0] blk_count;
   logic [SUM_W-1:0]   blk_sum;
   logic [SQ_W-1:0]    blk_sq;
   logic [POS_W-1:0]   stream_pos;
   logic [POS_W-1:0]   blk_first;

   result_type expected_blocks [$];
   int         error_count = 0;
   int         send_idle   = 0;
   int         recv_stall  = 0;
   logic       hold_rsp    = 1'b0;
   int         quiet_cycles = 0;

   plan_row_type directed_plan [28] = '{
      '{STEP_SAMPLE,     13'd0,    16'd10,    1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd20,    1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd30,    1'b1, 1'b0, '0},
      '{STEP_WRITE_SIZE, 13'd0,    16'd0,     1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd65535, 1'b0, 1'b1, '{32'd0, 13'd1, 24'hFFFF00, 24'd0}},
      '{STEP_SAMPLE,     13'd0,    16'd0,     1'b0, 1'b1, '{32'd1, 13'd1, 24'd0, 24'd0}},
      '{STEP_SAMPLE,     13'd0,    16'd1,     1'b1, 1'b1, '{32'd2, 13'd1, 24'd256, 24'd0}},
      '{STEP_WRITE_SIZE, 13'd8191, 16'd0,     1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd65535, 1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd65535, 1'b1, 1'b1, '{32'd0, 13'd2, 24'hFFFF00, 24'd0}},
      '{STEP_WRITE_SIZE, 13'd4,    16'd0,     1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd0,     1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd0,     1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd0,     1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd0,     1'b0, 1'b1, '{32'd0, 13'd4, 24'd0, 24'd0}},
      '{STEP_SAMPLE,     13'd0,    16'd0,     1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd0,     1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd0,     1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd65535, 1'b1, 1'b0, '0},
      '{STEP_WRITE_SIZE, 13'd10,   16'd0,     1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd100,   1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd200,   1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd300,   1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd400,   1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd500,   1'b0, 1'b0, '0},
      '{STEP_WRITE_SIZE, 13'd3,    16'd0,     1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd600,   1'b0, 1'b0, '0},
      '{STEP_SAMPLE,     13'd0,    16'd7,     1'b1, 1'b1, '{32'd6, 13'd1, 24'd1792, 24'd0}}
   };

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // largest q < 2^24 with (q*s)^2 <= d * 2^32
   function automatic logic [CV_W-1:0] ratio_root(input logic [63:0] d,
                                                  input logic [SUM_W-1:0] s);
      logic [127:0]    bound;
      logic [127:0]    prod;
      logic [CV_W-1:0] q;
      logic [CV_W-1:0] cand;
      bound = 128'(d) << 32;
      q = '0;
      for (int b = CV_W - 1; b >= 0; b--) begin
         cand = q | (24'd1 << b);
         prod = 128'(cand) * 128'(s);
         prod = prod * prod;
         if (prod <= bound)
            q = cand;
      end
      return q;
   endfunction

   function automatic bit advance_block_stats(input logic [SAMPLE_W-1:0] x,
                                              input logic last,
                                              output result_type blk);
      logic [COUNT_W-1:0] limit;
      logic [63:0]        nq;
      logic [63:0]        ss;
      logic [63:0]        dev;
      bit                 closed;
      blk = '0;
      if (size_reg == 0)
         limit = 13'd1;
      else if (size_reg > MAX_BLOCK)
         limit = 13'(MAX_BLOCK);
      else
         limit = size_reg;
      if (blk_count == 0)
         blk_first = stream_pos;
      blk_count  = blk_count + 1'b1;
      blk_sum    = blk_sum + SUM_W'(x);
      blk_sq     = blk_sq + SQ_W'(x) * SQ_W'(x);
      stream_pos = stream_pos + 1'b1;
      closed = (blk_count >= limit) || last;
      if (closed) begin
         nq  = 64'(blk_count) * 64'(blk_sq);
         ss  = 64'(blk_sum) * 64'(blk_sum);
         dev = (nq > ss) ? nq - ss : 64'd0;
         blk.start  = blk_first;
         blk.length = blk_count;
         blk.mean   = MEAN_W'((64'(blk_sum) << MEAN_FRAC) / 64'(blk_count));
         blk.cv     = (blk_sum == 0) ? '0 : ratio_root(dev, blk_sum);
         blk_count  = '0;
         blk_sum    = '0;
         blk_sq     = '0;
      end
      if (last)
         stream_pos = '0;
      return closed;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Response side: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_blocks.size() == 0) begin
               $display("%0t: response with none outstanding, start %0h length %0h",
                        $time, rsp_if.block_start, rsp_if.block_length);
               error_count++;
            end else begin
               check_field("block_start", expected_blocks[0].start, rsp_if.block_start);
               check_field("block_length", 32'(expected_blocks[0].length),
                           32'(rsp_if.block_length));
               check_field("mean_value", 32'(expected_blocks[0].mean),
                           32'(rsp_if.mean_value));
               check_field("variation_coeff", 32'(expected_blocks[0].cv),
                           32'(rsp_if.variation_coeff));
               void'(expected_blocks.pop_front());
            end
         end
         rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic push_sample(input logic [SAMPLE_W-1:0] x, input logic last,
                              input bit typed, input result_type known);
      result_type blk;
      bit         closed;
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.sample         <= x;
      req_if.last_of_stream <= last;
      do @(posedge clock); while (!req_if.ready);
      closed = advance_block_stats(x, last, blk);
      if (typed)
         expected_blocks.insert(expected_blocks.size(), known);
      else if (closed)
         expected_blocks.insert(expected_blocks.size(), blk);
   endtask

   task automatic write_span(input logic [COUNT_W-1:0] v);
      req_if.valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.span  <= v;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      size_reg = v;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(3))
         0: return SAMPLE_W'($urandom);
         1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         2: return SAMPLE_W'($urandom_range(15));
         default: return SAMPLE_W'($urandom_range(65000, 65535));
      endcase
   endfunction

   function automatic logic [COUNT_W-1:0] pick_span();
      case ($urandom_range(9))
         0: return COUNT_W'($urandom);
         1, 2: return COUNT_W'($urandom_range(25, 120));
         default: return COUNT_W'($urandom_range(1, 24));
      endcase
   endfunction

   task automatic random_phase(input int send_pct, input int stall_pct, input int n_items);
      int left;
      int seg;
      send_idle  = send_pct;
      recv_stall = stall_pct;
      left = n_items;
      while (left > 0) begin
         write_span(pick_span());
         seg = $urandom_range(40, 100);
         for (int i = 0; i < seg && left > 0; i++) begin
            push_sample(pick_sample(), $urandom_range(59) == 0, 1'b0, '0);
            left--;
         end
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.sample         <= '0;
      req_if.last_of_stream <= 1'b0;
      csr_if.valid          <= 1'b0;
      csr_if.span           <= '0;
      size_reg   = SPAN_RESET;
      blk_count  = '0;
      blk_sum    = '0;
      blk_sq     = '0;
      stream_pos = '0;
      blk_first  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_WRITE_SIZE)
            write_span(directed_plan[i].size);
         else
            push_sample(directed_plan[i].sample, directed_plan[i].last,
                        directed_plan[i].typed, directed_plan[i].known);
      end

      // receiver held off while requests keep coming, so the block backs up
      write_span(13'd2);
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      for (int i = 0; i < 60; i++)
         push_sample(pick_sample(), $urandom_range(19) == 0, 1'b0, '0);

      random_phase(0, 0, PHASE_ITEMS);
      random_phase(57, 0, PHASE_ITEMS);
      random_phase(0, 57, PHASE_ITEMS);
      random_phase(21, 21, PHASE_ITEMS);

      // near-max samples at the largest block size, closed by the end of stream
      send_idle  = 0;
      recv_stall = 0;
      write_span(13'd4096);
      for (int i = 0; i < TAIL_ITEMS; i++)
         push_sample(SAMPLE_W'($urandom_range(60000, 65535)), i == TAIL_ITEMS - 1,
                     1'b0, '0);

      req_if.valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
